// ----- src/pld_pkg.sv -----
// Shared types and constants of the levitation duty controller.
// Used by the divider, the datapath, the controller and the top level.
`timescale 1ns / 1ps

package pld_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int POS_W       = 10;
  localparam int GAIN_W      = 4;
  localparam int DIVR_W      = 8;
  localparam int PCT_W       = 7;
  localparam int PWM_W       = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int ERR_W       = 11;
  localparam int SUM_W       = 10;
  localparam int DIFF_W      = 12;
  localparam int DTERM_W     = 21;
  localparam int PID_W       = 22;
  localparam int CORR_W      = 26;
  localparam int DIV_W       = 26;
  localparam int DUTY_W      = 28;
  localparam int PREV_W      = 16;
  localparam int ACC_W       = 8;
  localparam int BOOST_W     = 4;

  localparam int SUM_LIMIT    = 1023;
  localparam int JUMP_LIMIT   = 10;
  localparam int BOOST_AT     = 10;
  localparam int FULL_DUTY    = 100;
  localparam int COMPARE_STEP = 312;
  localparam int PREV_RESET   = 50;
  localparam int PREV_MAX     = 32767;
  localparam int PREV_MIN     = -32768;

  localparam int TARGET_RESET = 533;
  localparam int GAIN_RESET   = 3;
  localparam int IDIV_RESET   = 7;
  localparam int PDIV_RESET   = 4;
  localparam int DGAIN_RESET  = 2;
  localparam int SDIV_RESET   = 13;
  localparam int DMAX_RESET   = 72;
  localparam int DTHR_RESET   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_GAIN,
    REG_IDIV,
    REG_PDIV,
    REG_DGAIN,
    REG_SDIV,
    REG_DMAX,
    REG_DTHR
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_SEL_INT,
    DIV_SEL_PROP,
    DIV_SEL_STEP
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT,
    S_INT_W,
    S_PROP,
    S_PROP_W,
    S_GAIN,
    S_STEP,
    S_STEP_W,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_int;
    logic     cap_prop;
    logic     cap_step;
    logic     deriv;
    logic     gain;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- src/pid_levitation_duty_controller.sv -----
// PID duty controller for a levitation loop: one sensor word in, one duty word out.
// Flow: a sample is taken, then three signed divisions (integral, proportional and duty step)
// run in turn on one divider producing two quotient bits per cycle, the overall gain being
// applied between the second and the third; the result is then committed. Each division has
// a start step, the quotient-bit steps and a capture step. The next sample can be accepted at
// the same edge at which the result word of the last one can first be taken.
// A new sample is taken only when the previous one has been committed; a finished result
// may still wait in the output register meanwhile. Depends on pld_pkg, pld_ctrl,
// pld_datapath and pld_div.
`timescale 1ns / 1ps

module pid_levitation_duty_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [11:0] sensor_sample, rest zero
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // [6:0] duty_percent,
                                                        // [21:7] pwm_compare, rest zero
  input  logic                           cfg_we_i,
  input  logic [pld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pld_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pld_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [PCT_W-1:0] duty;
  logic [PWM_W-1:0] pwm;

  pld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pld_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .duty_o      (duty),
    .pwm_o       (pwm)
  );

  assign m_axis_tdata = {{(24 - PWM_W - PCT_W){1'b0}}, pwm, duty};

  // The divider is never restarted while it is still working on a quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // A result is only committed when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> status.out_free)
    else $error("result committed over a waiting word");

  // Once a sample is taken, no further sample is accepted on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sample accepted while one is in flight");

  // The shown duty stays within full scale and the compare value matches it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (duty <= PCT_W'(FULL_DUTY)) &&
      (pwm == PWM_W'((PCT_W'(FULL_DUTY) - duty) * PWM_W'(COMPARE_STEP))))
    else $error("duty word out of range or compare value inconsistent");

endmodule

// ----- src/pld_div.sv -----
// Shared signed divider, two quotient bits per cycle, truncating toward zero.
// Depends on pld_pkg for the operand widths.
`timescale 1ns / 1ps

module pld_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pld_pkg::DIV_W-1:0]  dividend_i,
  input  logic        [pld_pkg::DIVR_W-1:0] divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [pld_pkg::DIV_W-1:0]  quotient_o
);
  import pld_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]  mag_q;
  logic [DIVR_W-1:0] dsr_q;
  logic [DIVR_W-1:0] rem_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DIVR_W:0]   t1, r1, t2, r2;
  logic              b1, b2;

  // Two restoring steps per cycle; the quotient bits shift in behind the dividend.
  always_comb begin
    t1 = {rem_q, mag_q[DIV_W-1]};
    b1 = (t1 >= {1'b0, dsr_q});
    r1 = b1 ? (t1 - {1'b0, dsr_q}) : t1;
    t2 = {r1[DIVR_W-1:0], mag_q[DIV_W-2]};
    b2 = (t2 >= {1'b0, dsr_q});
    r2 = b2 ? (t2 - {1'b0, dsr_q}) : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      mag_q <= dividend_i[DIV_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      // A divisor of zero behaves as one.
      dsr_q <= (divisor_i == '0) ? DIVR_W'(1) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DIV_W-3:0], b1, b2};
      rem_q <= r2[DIVR_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(~mag_q + 1'b1) : $signed(mag_q);

endmodule

// ----- src/pld_datapath.sv -----
// Datapath of the duty controller: settings, loop state, PID terms and the output word.
// Depends on pld_pkg and instantiates pld_div.
`timescale 1ns / 1ps

module pld_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pld_pkg::SAMPLE_W-1:0]       sample_i,
  input  pld_pkg::cmd_t                      cmd_i,
  output pld_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pld_pkg::PCT_W-1:0]          duty_o,
  output logic [pld_pkg::PWM_W-1:0]          pwm_o
);
  import pld_pkg::*;

  // Settings
  logic [POS_W-1:0]  target_q;
  logic [GAIN_W-1:0] gain_q;
  logic [DIVR_W-1:0] idiv_q, pdiv_q, dgain_q, sdiv_q;
  logic [PCT_W-1:0]  dmax_q, dthr_q;

  // Loop state
  logic        [SUM_W-1:0]   error_sum_q;
  logic signed [ERR_W-1:0]   last_err_q;
  logic        [ACC_W-1:0]   acc_q;
  logic signed [PREV_W-1:0]  prev_q;
  logic        [BOOST_W-1:0] boost_q;

  // Working registers of one sample
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DTERM_W-1:0] dterm_q;
  logic        [SUM_W-1:0]   iterm_q;
  logic signed [ERR_W-1:0]   pterm_q;
  logic signed [CORR_W-1:0]  corr_q;
  logic signed [DIV_W-1:0]   stepq_q;

  logic                      out_valid_q;
  logic [PCT_W-1:0]          out_duty_q;
  logic [PWM_W-1:0]          out_pwm_q;

  logic [POS_W-1:0]          sample10;
  logic signed [ERR_W-1:0]   err_w;
  logic signed [SUM_W+1:0]   sum_w;
  logic [SUM_W-1:0]          sum_clamped;
  logic signed [DIFF_W-1:0]  diff_w;
  logic signed [DTERM_W-1:0] dterm_w;
  logic signed [PID_W-1:0]   pid_w;
  logic signed [CORR_W-1:0]  corr_w;
  logic signed [DIV_W-1:0]   div_dividend;
  logic [DIVR_W-1:0]         div_divisor;
  logic signed [DIV_W-1:0]   div_quot;
  logic                      div_busy, div_done;

  logic signed [DUTY_W-1:0]  duty_w, jump_w, sel_w;
  logic                      reject;
  logic signed [PREV_W-1:0]  prev_d;
  logic [ACC_W-1:0]          lim_d;
  logic [BOOST_W-1:0]        boost_d;
  logic [PCT_W-1:0]          shown;
  logic [PCT_W-1:0]          rest;
  logic [PWM_W-1:0]          pwm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= POS_W'(TARGET_RESET);
      gain_q   <= GAIN_W'(GAIN_RESET);
      idiv_q   <= DIVR_W'(IDIV_RESET);
      pdiv_q   <= DIVR_W'(PDIV_RESET);
      dgain_q  <= DIVR_W'(DGAIN_RESET);
      sdiv_q   <= DIVR_W'(SDIV_RESET);
      dmax_q   <= PCT_W'(DMAX_RESET);
      dthr_q   <= PCT_W'(DTHR_RESET);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET: target_q <= cfg_data_i[POS_W-1:0];
        REG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_IDIV:   idiv_q   <= cfg_data_i[DIVR_W-1:0];
        REG_PDIV:   pdiv_q   <= cfg_data_i[DIVR_W-1:0];
        REG_DGAIN:  dgain_q  <= cfg_data_i[DIVR_W-1:0];
        REG_SDIV:   sdiv_q   <= cfg_data_i[DIVR_W-1:0];
        REG_DMAX:   dmax_q   <= cfg_data_i[PCT_W-1:0];
        REG_DTHR:   dthr_q   <= cfg_data_i[PCT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Error and clamped error sum, formed as the sample word is taken.
  always_comb begin
    sample10 = sample_i[SAMPLE_W-1:SAMPLE_W-POS_W];
    err_w    = $signed({1'b0, target_q}) - $signed({1'b0, sample10});
    sum_w    = $signed({2'b00, error_sum_q}) + $signed({err_w[ERR_W-1], err_w});
    if (sum_w > SUM_LIMIT) begin
      sum_clamped = SUM_W'(SUM_LIMIT);
    end else if (sum_w < 0) begin
      sum_clamped = '0;
    end else begin
      sum_clamped = sum_w[SUM_W-1:0];
    end
  end

  always_comb begin
    diff_w  = $signed({err_q[ERR_W-1], err_q}) - $signed({last_err_q[ERR_W-1], last_err_q});
    dterm_w = diff_w * $signed({1'b0, dgain_q});
    pid_w   = $signed({{(PID_W-ERR_W){pterm_q[ERR_W-1]}}, pterm_q})
            + $signed({{(PID_W-SUM_W){1'b0}}, iterm_q})
            + $signed({dterm_q[DTERM_W-1], dterm_q});
    corr_w  = pid_w * $signed({1'b0, gain_q});
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEL_INT: begin
        div_dividend = $signed({{(DIV_W-SUM_W){1'b0}}, error_sum_q});
        div_divisor  = idiv_q;
      end
      DIV_SEL_PROP: begin
        div_dividend = $signed({{(DIV_W-ERR_W){err_q[ERR_W-1]}}, err_q});
        div_divisor  = pdiv_q;
      end
      DIV_SEL_STEP: begin
        div_dividend = $signed({{(DIV_W-POS_W){1'b0}}, target_q}) - corr_q;
        div_divisor  = sdiv_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = idiv_q;
      end
    endcase
  end

  pld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Jump rejection, previous-duty saturation and limiting with the periodic boost.
  always_comb begin
    duty_w = $signed({{(DUTY_W-ACC_W){1'b0}}, acc_q})
           + $signed({{(DUTY_W-DIV_W){stepq_q[DIV_W-1]}}, stepq_q});
    jump_w = duty_w - $signed({{(DUTY_W-PREV_W){prev_q[PREV_W-1]}}, prev_q});
    reject = (jump_w > JUMP_LIMIT) || (jump_w < -JUMP_LIMIT);
    sel_w  = reject ? $signed({{(DUTY_W-PREV_W){prev_q[PREV_W-1]}}, prev_q}) : duty_w;

    if (sel_w > PREV_MAX) begin
      prev_d = PREV_W'(PREV_MAX);
    end else if (sel_w < PREV_MIN) begin
      prev_d = PREV_W'(PREV_MIN);
    end else begin
      prev_d = sel_w[PREV_W-1:0];
    end

    boost_d = boost_q;
    if (sel_w > $signed({1'b0, dthr_q})) begin
      if (boost_q == BOOST_W'(BOOST_AT)) begin
        lim_d   = ACC_W'({1'b0, dmax_q}) + ACC_W'(2);
        boost_d = BOOST_W'(1);
      end else begin
        lim_d   = ACC_W'({1'b0, dmax_q});
        boost_d = boost_q + 1'b1;
      end
    end else if (sel_w < 0) begin
      lim_d = '0;
    end else begin
      lim_d = sel_w[ACC_W-1:0];
    end

    shown = (lim_d > ACC_W'(FULL_DUTY)) ? PCT_W'(FULL_DUTY) : lim_d[PCT_W-1:0];
    rest  = PCT_W'(FULL_DUTY) - shown;
    pwm_d = PWM_W'(rest * PWM_W'(COMPARE_STEP));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      last_err_q  <= '0;
      acc_q       <= '0;
      prev_q      <= PREV_W'(PREV_RESET);
      boost_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        error_sum_q <= sum_clamped;
      end
      if (cmd_i.deriv) begin
        last_err_q <= err_q;
      end
      if (cmd_i.commit) begin
        acc_q       <= lim_d;
        prev_q      <= prev_d;
        boost_q     <= boost_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load)     err_q     <= err_w;
    if (cmd_i.deriv)    dterm_q   <= dterm_w;
    if (cmd_i.cap_int)  iterm_q   <= div_quot[SUM_W-1:0];
    if (cmd_i.cap_prop) pterm_q   <= div_quot[ERR_W-1:0];
    if (cmd_i.gain)     corr_q    <= corr_w;
    if (cmd_i.cap_step) stepq_q   <= div_quot;
    if (cmd_i.commit) begin
      out_duty_q <= shown;
      out_pwm_q  <= pwm_d;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign pwm_o       = out_pwm_q;

endmodule

// ----- src/pld_ctrl.sv -----
// Sequencer of the duty controller: walks one sample through the shared divider.
// Depends on pld_pkg for the state, command and status types.
`timescale 1ns / 1ps

module pld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pld_pkg::status_t  status_i,
  output pld_pkg::cmd_t     cmd_o
);
  import pld_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_SEL_INT;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_INT;
        end
      end
      S_INT: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_INT;
        cmd_o.deriv     = 1'b1;
        state_d         = S_INT_W;
      end
      S_INT_W: begin
        if (status_i.div_done) begin
          cmd_o.cap_int = 1'b1;
          state_d       = S_PROP;
        end
      end
      S_PROP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_PROP;
        state_d         = S_PROP_W;
      end
      S_PROP_W: begin
        if (status_i.div_done) begin
          cmd_o.cap_prop = 1'b1;
          state_d        = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEL_STEP;
        state_d         = S_STEP_W;
      end
      S_STEP_W: begin
        cmd_o.div_sel = DIV_SEL_STEP;
        if (status_i.div_done) begin
          cmd_o.cap_step = 1'b1;
          state_d        = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // The result word waits here until the output register is free.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
